[rtl/core/dtp_pkg.sv]
// ----------------------------------------------------------------------------
// Display test pattern package
// Shared constants, types and helper functions of the test pattern pipeline.
// ----------------------------------------------------------------------------
package dtp_pkg;

    localparam int unsigned CFG_W      = 11;
    localparam int unsigned POS_W      = 10;
    localparam int unsigned COLOR_W    = 24;
    localparam int unsigned DIVIDEND_W = 18;
    localparam int unsigned IDX_W      = 3;
    localparam int unsigned BAR_W      = 3;

    localparam logic [CFG_W-1:0] MAX_WIDTH  = CFG_W'(1024);
    localparam logic [CFG_W-1:0] MAX_HEIGHT = CFG_W'(1024);

    localparam logic [IDX_W-1:0] REG_FRAME_WIDTH  = 3'd0;
    localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
    localparam logic [IDX_W-1:0] REG_PATTERN_MODE = 3'd2;
    localparam logic [IDX_W-1:0] REG_SOLID_COLOR  = 3'd3;
    localparam logic [IDX_W-1:0] REG_PIXEL_FORMAT = 3'd4;

    localparam logic [1:0] MODE_BARS   = 2'd0;
    localparam logic [1:0] MODE_GREY   = 2'd1;
    localparam logic [1:0] MODE_SOLID  = 2'd2;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    localparam logic FMT_RGB565 = 1'b0;
    localparam logic FMT_RGB888 = 1'b1;

    localparam logic [CFG_W-1:0]   RST_FRAME_WIDTH  = CFG_W'(240);
    localparam logic [CFG_W-1:0]   RST_FRAME_HEIGHT = CFG_W'(240);
    localparam logic [COLOR_W-1:0] RST_SOLID_COLOR  = 24'hFF0000;

    localparam logic [15:0] RGB565_BAR_MASK = 16'hFFDF;
    localparam logic [7:0]  MASK_5BIT       = 8'hF8;
    localparam logic [7:0]  MASK_6BIT       = 8'hFC;
    localparam logic [7:0]  CHAN_FULL       = 8'hFF;
    localparam logic [7:0]  CHAN_GREY       = 8'h77;
    localparam logic [7:0]  GREY_FACTOR     = 8'd119;

    typedef struct packed {
        logic [CFG_W-1:0]   frame_width;
        logic [CFG_W-1:0]   frame_height;
        logic [1:0]         pattern_mode;
        logic [COLOR_W-1:0] solid_color;
        logic               pixel_format;
    } t_cfg;

    typedef struct packed {
        logic [BAR_W-1:0] bar;
        logic             in_bar;
        logic             sat;
        logic             wz;
        logic [7:0]       grey;
    } t_pix;

    typedef struct packed {
        logic [POS_W-1:0] rem;
        logic [7:0]       lo;
        logic [7:0]       quo;
    } t_div;

    typedef struct packed {
        t_pix pix;
        t_div d255;
        t_div d119;
    } t_stage;

    function automatic logic [CFG_W-1:0] clamp_dim(input logic [CFG_W-1:0] v,
                                                   input logic [CFG_W-1:0] lim);
        return (v > lim) ? lim : v;
    endfunction

    function automatic t_div div_step(input t_div s, input logic [CFG_W-1:0] w);
        logic [CFG_W-1:0] t;
        t_div             r;
        t = {s.rem, s.lo[7]};
        r.lo = {s.lo[6:0], 1'b0};
        if (t >= w) begin
            r.rem = POS_W'(t - w);
            r.quo = {s.quo[6:0], 1'b1};
        end else begin
            r.rem = POS_W'(t);
            r.quo = {s.quo[6:0], 1'b0};
        end
        return r;
    endfunction

    function automatic logic [COLOR_W-1:0] bar_color(input logic [BAR_W-1:0] idx);
        case (idx)
            3'd0:    return 24'hFFFFFF;
            3'd1:    return 24'h777777;
            3'd2:    return 24'hFF0000;
            3'd3:    return 24'h00FF00;
            3'd4:    return 24'h0000FF;
            3'd5:    return 24'h00FFFF;
            3'd6:    return 24'hFF00FF;
            3'd7:    return 24'hFFFF00;
            default: return 24'h000000;
        endcase
    endfunction

    function automatic logic [COLOR_W-1:0] pack_pixel(input logic [COLOR_W-1:0] rgb,
                                                      input logic fmt);
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        r = rgb[23:16];
        g = rgb[15:8];
        b = rgb[7:0];
        if (fmt == FMT_RGB565) begin
            return {8'h00, r[7:3], g[7:2], b[7:3]};
        end
        return rgb;
    endfunction

endpackage

[rtl/core/dtp_front.sv]
// ----------------------------------------------------------------------------
// Test pattern front stage
// Finds the bar of the row, the ramp flags and the two divider dividends.
// ----------------------------------------------------------------------------
module dtp_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_valid,
    input  logic [dtp_pkg::POS_W-1:0]  i_pos_x,
    input  logic [dtp_pkg::POS_W-1:0]  i_pos_y,
    input  dtp_pkg::t_cfg              i_cfg,
    output logic                       o_valid,
    output dtp_pkg::t_stage            o_stage
);

    logic [dtp_pkg::CFG_W-1:0]      w;
    logic [dtp_pkg::CFG_W-1:0]      h;
    logic [7:0]                     bar_h;
    logic [8:1]                     ge;
    logic [dtp_pkg::BAR_W-1:0]      bar;
    logic [dtp_pkg::DIVIDEND_W-1:0] d255;
    logic [dtp_pkg::DIVIDEND_W-1:0] d119;
    dtp_pkg::t_stage                n_stage;
    dtp_pkg::t_stage                r_stage;
    logic                           r_valid;

    always_comb begin
        w     = dtp_pkg::clamp_dim(i_cfg.frame_width, dtp_pkg::MAX_WIDTH);
        h     = dtp_pkg::clamp_dim(i_cfg.frame_height, dtp_pkg::MAX_HEIGHT);
        bar_h = h[10:3];
        for (int k = 1; k <= 8; k++) begin
            ge[k] = {1'b0, i_pos_y} >= (dtp_pkg::CFG_W'(k) * dtp_pkg::CFG_W'(bar_h));
        end
        bar = '0;
        for (int k = 1; k <= 7; k++) begin
            if (ge[k]) begin
                bar = dtp_pkg::BAR_W'(k);
            end
        end
        d255 = {i_pos_x, 8'h00} - dtp_pkg::DIVIDEND_W'(i_pos_x);
        d119 = dtp_pkg::DIVIDEND_W'(i_pos_x) * dtp_pkg::DIVIDEND_W'(dtp_pkg::GREY_FACTOR);

        n_stage.pix.bar    = bar;
        n_stage.pix.in_bar = (bar_h != 8'd0) && !ge[8];
        n_stage.pix.sat    = {1'b0, i_pos_x} >= w;
        n_stage.pix.wz     = (w == '0);
        n_stage.pix.grey   = i_pos_y[7:0];
        n_stage.d255.rem   = d255[17:8];
        n_stage.d255.lo    = d255[7:0];
        n_stage.d255.quo   = '0;
        n_stage.d119.rem   = d119[17:8];
        n_stage.d119.lo    = d119[7:0];
        n_stage.d119.quo   = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_stage <= n_stage;
        end
    end

    assign o_valid = r_valid;
    assign o_stage = r_stage;

endmodule

[rtl/core/dtp_div_stage.sv]
// ----------------------------------------------------------------------------
// Test pattern divider stage
// Two restoring division steps for each of the two ramp quotients.
// ----------------------------------------------------------------------------
module dtp_div_stage (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_valid,
    input  dtp_pkg::t_stage           i_stage,
    input  logic [dtp_pkg::CFG_W-1:0] i_width,
    output logic                      o_valid,
    output dtp_pkg::t_stage           o_stage
);

    logic [dtp_pkg::CFG_W-1:0] w;
    dtp_pkg::t_stage           n_stage;
    dtp_pkg::t_stage           r_stage;
    logic                      r_valid;

    always_comb begin
        w            = dtp_pkg::clamp_dim(i_width, dtp_pkg::MAX_WIDTH);
        n_stage.pix  = i_stage.pix;
        n_stage.d255 = dtp_pkg::div_step(dtp_pkg::div_step(i_stage.d255, w), w);
        n_stage.d119 = dtp_pkg::div_step(dtp_pkg::div_step(i_stage.d119, w), w);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_stage <= n_stage;
        end
    end

    assign o_valid = r_valid;
    assign o_stage = r_stage;

endmodule

[rtl/core/dtp_out.sv]
// ----------------------------------------------------------------------------
// Test pattern output stage
// Selects the pattern color, packs it and holds the result register.
// ----------------------------------------------------------------------------
module dtp_out (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  dtp_pkg::t_stage             i_stage,
    input  dtp_pkg::t_cfg               i_cfg,
    output logic                        o_valid,
    output logic [dtp_pkg::COLOR_W-1:0] o_pixel_word,
    output logic                        o_in_pattern
);

    logic [dtp_pkg::COLOR_W-1:0] base;
    logic [dtp_pkg::COLOR_W-1:0] ramped;
    logic [dtp_pkg::COLOR_W-1:0] bar_word;
    logic [7:0]                  c;
    logic [dtp_pkg::COLOR_W-1:0] n_word;
    logic                        n_inside;
    logic [dtp_pkg::COLOR_W-1:0] r_word;
    logic                        r_inside;
    logic                        r_valid;

    always_comb begin
        base = dtp_pkg::bar_color(i_stage.pix.bar);
        for (int ch = 0; ch < 3; ch++) begin
            c = base[ch*8 +: 8];
            if (i_stage.pix.wz) begin
                ramped[ch*8 +: 8] = 8'h00;
            end else if (i_stage.pix.sat) begin
                ramped[ch*8 +: 8] = c;
            end else if (c == dtp_pkg::CHAN_FULL) begin
                ramped[ch*8 +: 8] = i_stage.d255.quo;
            end else if (c == dtp_pkg::CHAN_GREY) begin
                ramped[ch*8 +: 8] = i_stage.d119.quo;
            end else begin
                ramped[ch*8 +: 8] = 8'h00;
            end
        end
        bar_word = dtp_pkg::pack_pixel(ramped, i_cfg.pixel_format);
        if (i_cfg.pixel_format == dtp_pkg::FMT_RGB565) begin
            bar_word[15:0] = bar_word[15:0] & dtp_pkg::RGB565_BAR_MASK;
        end

        case (i_cfg.pattern_mode)
            dtp_pkg::MODE_BARS: begin
                n_word   = i_stage.pix.in_bar ? bar_word : '0;
                n_inside = i_stage.pix.in_bar;
            end
            dtp_pkg::MODE_GREY: begin
                n_word   = dtp_pkg::pack_pixel({3{i_stage.pix.grey}}, i_cfg.pixel_format);
                n_inside = 1'b1;
            end
            dtp_pkg::MODE_SOLID: begin
                n_word   = dtp_pkg::pack_pixel(i_cfg.solid_color, i_cfg.pixel_format);
                n_inside = 1'b1;
            end
            default: begin
                n_word   = '0;
                n_inside = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_word   <= n_word;
            r_inside <= n_inside;
        end
    end

    assign o_valid      = r_valid;
    assign o_pixel_word = r_word;
    assign o_in_pattern = r_inside;

endmodule

[rtl/core/display_test_pattern_pixel.sv]
// ----------------------------------------------------------------------------
// Display test pattern pixel generator
// Returns the color bar, grey ramp or solid fill pixel for a pixel position.
// ----------------------------------------------------------------------------
// The block takes one pixel position per clock and returns its pixel
// through a six-stage pipeline: a front stage that finds the bar and the
// ramp dividends, four stages of a radix-4 restoring divider that forms the
// horizontal ramp, and an output register that selects and packs the color.
// Throughput is one transaction per clock whenever the output side takes
// results. Each stage fills its empty slot, so input transactions are
// accepted until the pipeline is full while a result waits. Configuration
// writes are always accepted and must only be made while no pixel is in
// flight.
module display_test_pattern_pixel (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [dtp_pkg::POS_W-1:0]   i_pos_x,
    input  logic [dtp_pkg::POS_W-1:0]   i_pos_y,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [dtp_pkg::COLOR_W-1:0] o_pixel_word,
    output logic                        o_in_pattern,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [dtp_pkg::IDX_W-1:0]   i_cfg_index,
    input  logic [dtp_pkg::COLOR_W-1:0] i_cfg_data
);

    localparam int unsigned DIV_STAGES = 4;

    dtp_pkg::t_cfg   r_cfg;
    dtp_pkg::t_stage stage [DIV_STAGES+1];
    logic            valid [DIV_STAGES+1];
    logic            en    [DIV_STAGES+2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.frame_width  <= dtp_pkg::RST_FRAME_WIDTH;
            r_cfg.frame_height <= dtp_pkg::RST_FRAME_HEIGHT;
            r_cfg.pattern_mode <= dtp_pkg::MODE_BARS;
            r_cfg.solid_color  <= dtp_pkg::RST_SOLID_COLOR;
            r_cfg.pixel_format <= dtp_pkg::FMT_RGB565;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                dtp_pkg::REG_FRAME_WIDTH:  r_cfg.frame_width  <= i_cfg_data[10:0];
                dtp_pkg::REG_FRAME_HEIGHT: r_cfg.frame_height <= i_cfg_data[10:0];
                dtp_pkg::REG_PATTERN_MODE: r_cfg.pattern_mode <= i_cfg_data[1:0];
                dtp_pkg::REG_SOLID_COLOR:  r_cfg.solid_color  <= i_cfg_data;
                dtp_pkg::REG_PIXEL_FORMAT: r_cfg.pixel_format <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    always_comb begin
        en[DIV_STAGES+1] = !o_out_valid || i_out_ready;
        for (int s = DIV_STAGES; s >= 0; s--) begin
            en[s] = !valid[s] || en[s+1];
        end
    end

    assign o_in_ready = en[0];

    dtp_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en[0]),
        .i_valid (i_in_valid),
        .i_pos_x (i_pos_x),
        .i_pos_y (i_pos_y),
        .i_cfg   (r_cfg),
        .o_valid (valid[0]),
        .o_stage (stage[0])
    );

    for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
        dtp_div_stage u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en[g+1]),
            .i_valid (valid[g]),
            .i_stage (stage[g]),
            .i_width (r_cfg.frame_width),
            .o_valid (valid[g+1]),
            .o_stage (stage[g+1])
        );
    end

    dtp_out u_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (en[DIV_STAGES+1]),
        .i_valid      (valid[DIV_STAGES]),
        .i_stage      (stage[DIV_STAGES]),
        .i_cfg        (r_cfg),
        .o_valid      (o_out_valid),
        .o_pixel_word (o_pixel_word),
        .o_in_pattern (o_in_pattern)
    );

    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready && valid[0] && valid[1] && valid[2]
         && valid[3] && valid[4]) |-> !o_in_ready)
        else $error("full stalled pipeline still accepts input");

    a_unused_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && r_cfg.pattern_mode == dtp_pkg::MODE_UNUSED)
        |-> (!o_in_pattern && o_pixel_word == '0))
        else $error("unused mode gave a pattern pixel");

    a_fill_modes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (r_cfg.pattern_mode == dtp_pkg::MODE_GREY
                         || r_cfg.pattern_mode == dtp_pkg::MODE_SOLID))
        |-> o_in_pattern)
        else $error("fill mode pixel outside pattern");

    a_rgb565_width: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && r_cfg.pixel_format == dtp_pkg::FMT_RGB565)
        |-> (o_pixel_word[23:16] == 8'h00))
        else $error("RGB565 pixel has upper byte set");

    a_outside_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_in_pattern) |-> (o_pixel_word == '0))
        else $error("pixel outside pattern is not zero");

endmodule
